// ===== rtl/philox_pkg.sv =====
// Package for the Philox4x32 counter-based generator.
// Beat types, command and register codes, round constants. No dependencies.

package philox_pkg;

    localparam int unsigned ROUNDS  = 10;
    localparam int unsigned ROUND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    localparam logic [31:0] MUL_A  = 32'hD251_1F53;
    localparam logic [31:0] MUL_B  = 32'hCD9E_8D57;
    localparam logic [31:0] WEYL_A = 32'h9E37_79B9;
    localparam logic [31:0] WEYL_B = 32'hBB67_AE85;

    localparam logic [31:0] KEY0_RST   = 32'd56;
    localparam logic [31:0] KEY1_RST   = 32'd712;
    localparam logic [31:0] START0_RST = 32'd1;
    localparam logic [31:0] START1_RST = 32'd2;
    localparam logic [31:0] START2_RST = 32'd3;
    localparam logic [31:0] START3_RST = 32'd3;

    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0   = 3'd0,
        REG_KEY1   = 3'd1,
        REG_START0 = 3'd2,
        REG_START1 = 3'd3,
        REG_START2 = 3'd4,
        REG_START3 = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        CMD_GEN     = 2'd0,
        CMD_SKIP    = 2'd1,
        CMD_RESTART = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] skip_count;
    } t_in_item;

    typedef struct packed {
        logic [31:0] rand_word0;
        logic [31:0] rand_word1;
        logic [31:0] rand_word2;
        logic [31:0] rand_word3;
    } t_out_item;

endpackage

// ===== rtl/philox_counter_rng_unit.sv =====
// Philox4x32 counter-based random generator, top level.
// Depends on philox_pkg for beat types, codes and round constants.

// A generate beat runs ROUNDS Philox rounds, one per cycle, on a single pair of
// 32x32 multipliers, registers the four words into the output slot, then adds
// one to the 128-bit counter (low half, then carry into the high half). Input
// ready is held low for the whole sequence, including any wait for the previous
// result to be taken before the words can enter the output slot. A skip beat
// runs the same low-then-high counter add; a restart or an unused command is
// handled in idle and leaves input ready high. Config writes are always
// accepted and belong in idle time.
module philox_counter_rng_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  philox_pkg::t_in_item                 i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output philox_pkg::t_out_item                o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [philox_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                          i_cfg_data
);
    import philox_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_EMIT,
        S_ADD_LO,
        S_ADD_HI
    } t_state;

    t_state               r_state;
    logic [ROUND_W-1:0]   r_round;
    logic [31:0]          r_key0, r_key1;
    logic [31:0]          r_start0, r_start1, r_start2, r_start3;
    logic [63:0]          r_ctr_lo, r_ctr_hi;
    logic [63:0]          r_amount;
    logic                 r_carry;
    logic [31:0]          r_w0, r_w1, r_w2, r_w3;
    logic [31:0]          r_k0, r_k1;
    logic                 r_out_valid;
    t_out_item            r_out_data;

    logic                 in_fire;
    logic                 out_free;
    logic [63:0]          prod0, prod1;
    logic [31:0]          n_w0, n_w1, n_w2, n_w3;
    logic [64:0]          sum_lo;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Shared round datapath: one Philox round on the working words
    always_comb begin
        prod0 = 64'(MUL_A) * 64'(r_w0);
        prod1 = 64'(MUL_B) * 64'(r_w2);
        n_w0  = prod1[63:32] ^ r_w1 ^ r_k0;
        n_w1  = prod1[31:0];
        n_w2  = prod0[63:32] ^ r_w3 ^ r_k1;
        n_w3  = prod0[31:0];
    end

    assign sum_lo = {1'b0, r_ctr_lo} + {1'b0, r_amount};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_round     <= '0;
            r_out_valid <= 1'b0;
            r_key0      <= KEY0_RST;
            r_key1      <= KEY1_RST;
            r_start0    <= START0_RST;
            r_start1    <= START1_RST;
            r_start2    <= START2_RST;
            r_start3    <= START3_RST;
            r_ctr_lo    <= {START1_RST, START0_RST};
            r_ctr_hi    <= {START3_RST, START2_RST};
        end else begin
            // slot fills from emit, else empties on a taken beat
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_KEY0:   r_key0   <= i_cfg_data;
                    REG_KEY1:   r_key1   <= i_cfg_data;
                    REG_START0: r_start0 <= i_cfg_data;
                    REG_START1: r_start1 <= i_cfg_data;
                    REG_START2: r_start2 <= i_cfg_data;
                    REG_START3: r_start3 <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        case (i_in_data.command)
                            CMD_GEN: begin
                                r_w0    <= r_ctr_lo[31:0];
                                r_w1    <= r_ctr_lo[63:32];
                                r_w2    <= r_ctr_hi[31:0];
                                r_w3    <= r_ctr_hi[63:32];
                                r_k0    <= r_key0;
                                r_k1    <= r_key1;
                                r_round <= '0;
                                r_state <= S_ROUND;
                            end
                            CMD_SKIP: begin
                                r_amount <= i_in_data.skip_count;
                                r_state  <= S_ADD_LO;
                            end
                            CMD_RESTART: begin
                                r_ctr_lo <= {r_start1, r_start0};
                                r_ctr_hi <= {r_start3, r_start2};
                            end
                            default: ;  // unused code: dropped
                        endcase
                    end
                end
                S_ROUND: begin
                    r_w0  <= n_w0;
                    r_w1  <= n_w1;
                    r_w2  <= n_w2;
                    r_w3  <= n_w3;
                    r_k0  <= r_k0 + WEYL_A;
                    r_k1  <= r_k1 + WEYL_B;
                    r_round <= r_round + 1'b1;
                    if (r_round == ROUND_W'(ROUNDS - 1)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // hold the words until the output slot is free
                    if (out_free) begin
                        r_out_data  <= '{rand_word0: r_w0, rand_word1: r_w1,
                                         rand_word2: r_w2, rand_word3: r_w3};
                        r_amount    <= 64'd1;
                        r_state     <= S_ADD_LO;
                    end
                end
                S_ADD_LO: begin
                    r_ctr_lo <= sum_lo[63:0];
                    r_carry  <= sum_lo[64];
                    r_state  <= S_ADD_HI;
                end
                S_ADD_HI: begin
                    r_ctr_hi <= r_ctr_hi + 64'(r_carry);
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_round <= ROUND_W'(ROUNDS - 1)))
        else $error("round counter ran past last round");

    a_add_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD_LO) |=> (r_state == S_ADD_HI))
        else $error("counter high half not updated after low half");

    a_emit_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |=> (r_state == S_EMIT || r_state == S_ADD_LO))
        else $error("generate left emit without counter increment");

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_out_valid && !i_out_ready) |=> (r_state == S_EMIT))
        else $error("result written over a beat not yet taken");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.command == CMD_RESTART)
        |=> (r_ctr_lo == {$past(r_start1), $past(r_start0)}
             && r_ctr_hi == {$past(r_start3), $past(r_start2)}))
        else $error("restart did not load start words");

endmodule

// ===== verif/philox_stream_checker.sv =====
// Checker for the Philox4x32 generator: follows register writes and input beats,
// predicts each generated block and compares output beats in order.
// Depends on philox_pkg for beat types, command and register codes.

module philox_stream_checker
    import philox_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    output int                    o_mismatches,
    output int                    o_outstanding
);

    localparam logic [31:0] PH_MUL0  = 32'hD251_1F53;
    localparam logic [31:0] PH_MUL1  = 32'hCD9E_8D57;
    localparam logic [31:0] PH_WEYL0 = 32'h9E37_79B9;
    localparam logic [31:0] PH_WEYL1 = 32'hBB67_AE85;

    logic [31:0]  key0;
    logic [31:0]  key1;
    logic [31:0]  start_words [4];
    logic [127:0] block_ctr;
    t_out_item    expected_blocks [$];

    // Ten (ROUNDS) dependent rounds on the 128-bit counter, word 0 lowest.
    function automatic t_out_item philox_block(input logic [127:0] ctr,
                                               input logic [31:0]  k0_in,
                                               input logic [31:0]  k1_in);
        logic [31:0] w0, w1, w2, w3, k0, k1;
        logic [63:0] p0, p1;
        t_out_item   blk;
        {w3, w2, w1, w0} = ctr;
        k0 = k0_in;
        k1 = k1_in;
        for (int r = 0; r < ROUNDS; r++) begin
            p0 = {32'd0, w0} * {32'd0, PH_MUL0};
            p1 = {32'd0, w2} * {32'd0, PH_MUL1};
            {w0, w1, w2, w3} = {p1[63:32] ^ w1 ^ k0, p1[31:0],
                                p0[63:32] ^ w3 ^ k1, p0[31:0]};
            k0 = k0 + PH_WEYL0;
            k1 = k1 + PH_WEYL1;
        end
        blk.rand_word0 = w0;
        blk.rand_word1 = w1;
        blk.rand_word2 = w2;
        blk.rand_word3 = w3;
        return blk;
    endfunction

    always @(posedge i_clk) begin : track
        t_out_item        want;
        logic [3:0][31:0] want_w;
        logic [3:0][31:0] got_w;
        if (!i_rst_n) begin
            key0 = 32'd56;
            key1 = 32'd712;
            start_words = '{32'd1, 32'd2, 32'd3, 32'd3};
            block_ctr = {32'd3, 32'd3, 32'd2, 32'd1};
            expected_blocks.delete();
            o_mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_KEY0:   key0 = i_cfg_data;
                    REG_KEY1:   key1 = i_cfg_data;
                    REG_START0: start_words[0] = i_cfg_data;
                    REG_START1: start_words[1] = i_cfg_data;
                    REG_START2: start_words[2] = i_cfg_data;
                    REG_START3: start_words[3] = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_out_valid && i_out_ready) begin
                if (expected_blocks.size() == 0) begin
                    $display("%0t: output beat with nothing expected, got %h",
                             $time, i_out_data);
                    o_mismatches++;
                end else begin
                    want = expected_blocks.pop_front();
                    want_w = want;
                    got_w = i_out_data;
                    // rand_word0 sits in the top 32 bits of the packed struct
                    for (int i = 3; i >= 0; i--) begin
                        if (want_w[i] !== got_w[i]) begin
                            $display("%0t: rand_word%0d expected %h, got %h",
                                     $time, 3 - i, want_w[i], got_w[i]);
                            o_mismatches++;
                        end
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                case (i_in_data.command)
                    CMD_GEN: begin
                        expected_blocks.push_back(philox_block(block_ctr, key0, key1));
                        block_ctr = block_ctr + 128'd1;
                    end
                    CMD_SKIP:    block_ctr = block_ctr + {64'd0, i_in_data.skip_count};
                    CMD_RESTART: block_ctr = {start_words[3], start_words[2],
                                              start_words[1], start_words[0]};
                    default: ;
                endcase
            end
        end
        o_outstanding = expected_blocks.size();
    end

endmodule

// ===== verif/philox_counter_rng_unit_tb.sv =====
// Top of the Philox4x32 generator testbench: clock, reset, stimulus, verdict.
// Depends on philox_pkg, philox_counter_rng_unit and philox_stream_checker.

module philox_counter_rng_unit_tb;
    import philox_pkg::*;

    localparam logic [1:0]           CMD_UNUSED      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;
    localparam logic [63:0]          ALL_ONES64      = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int                   SETTLE_CYCLES   = ROUNDS + 10;
    localparam int                   LONG_HOLD_CYCLES = 300;
    localparam int                   RANDOM_PER_PHASE = 125;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [31:0]           cfg_data  = '0;
    int                    mismatches;
    int                    outstanding;
    int                    burst_left = 0;
    int                    long_hold  = 0;

    always #5 clk = ~clk;

    philox_counter_rng_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    philox_stream_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Sender: bursts of beats with random gaps; valid stays up inside a burst.
    task automatic send_item(input logic [1:0] cmd, input logic [63:0] count);
        if (burst_left <= 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_data  <= {cmd, count};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
    endtask

    task automatic run_random(input int n);
        logic [1:0]  cmd;
        logic [63:0] count;
        int          pick;
        repeat (n) begin
            pick  = $urandom_range(0, 99);
            count = {$urandom, $urandom};
            if (pick < 70) begin
                cmd = CMD_GEN;
            end else if (pick < 85) begin
                cmd = CMD_SKIP;
                case ($urandom_range(0, 3))
                    0: count = 64'($urandom_range(0, 15));
                    1: count = ALL_ONES64 - 64'($urandom_range(0, 15));
                    default: ;
                endcase
            end else if (pick < 93) begin
                cmd = CMD_RESTART;
            end else begin
                cmd = CMD_UNUSED;
            end
            send_item(cmd, count);
        end
    endtask

    // Wait for every block to come out, then let the counter update finish.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic load_config(input logic [31:0] k0, input logic [31:0] k1,
                               input logic [31:0] s0, input logic [31:0] s1,
                               input logic [31:0] s2, input logic [31:0] s3);
        write_reg(REG_KEY0, k0);
        write_reg(REG_UNMAPPED_LO, $urandom);
        write_reg(REG_KEY1, k1);
        write_reg(REG_START0, s0);
        write_reg(REG_START1, s1);
        write_reg(REG_UNMAPPED_HI, $urandom);
        write_reg(REG_START2, s2);
        write_reg(REG_START3, s3);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: runs of always-ready, random, mostly-stalled and mostly-ready ready,
    // plus one long hold-off on request.
    initial begin : receiver
        int mode;
        int run_len;
        forever begin
            if (long_hold > 0) begin
                out_ready <= 1'b0;
                repeat (long_hold) @(posedge clk);
                long_hold = 0;
            end else begin
                mode    = $urandom_range(0, 3);
                run_len = $urandom_range(4, 40);
                repeat (run_len) begin
                    case (mode)
                        0: out_ready <= 1'b1;
                        1: out_ready <= 1'($urandom_range(0, 1));
                        2: out_ready <= ($urandom_range(0, 3) == 0);
                        default: out_ready <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial begin : limit
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: counter starts at words 1,2,3,3
        send_item(CMD_GEN, ALL_ONES64);
        send_item(CMD_GEN, 64'd0);
        send_item(CMD_SKIP, 64'd0);
        send_item(CMD_GEN, {$urandom, $urandom});
        send_item(CMD_SKIP, ALL_ONES64);            // carry into the high half
        send_item(CMD_GEN, {$urandom, $urandom});
        send_item(CMD_UNUSED, ALL_ONES64);          // ignored
        send_item(CMD_GEN, {$urandom, $urandom});
        send_item(CMD_RESTART, ALL_ONES64);         // count ignored
        send_item(CMD_GEN, {$urandom, $urandom});
        send_item(CMD_SKIP, 64'h8000_0000_0000_0000);
        send_item(CMD_SKIP, 64'h8000_0000_0000_0000);
        send_item(CMD_GEN, {$urandom, $urandom});
        send_item(CMD_SKIP, 64'd1);
        send_item(CMD_GEN, {$urandom, $urandom});

        // long receiver hold-off while generate beats keep coming
        long_hold  = LONG_HOLD_CYCLES;
        burst_left = 20;
        repeat (8) send_item(CMD_GEN, {$urandom, $urandom});
        drain();

        // all ones: the first block runs at the top of the counter, which wraps
        load_config('1, '1, '1, '1, '1, '1);
        send_item(CMD_RESTART, 64'd0);
        send_item(CMD_GEN, 64'd0);
        send_item(CMD_GEN, 64'd0);
        send_item(CMD_RESTART, {$urandom, $urandom});
        send_item(CMD_SKIP, 64'd1);                 // whole counter wraps to zero
        send_item(CMD_GEN, ALL_ONES64);
        run_random(RANDOM_PER_PHASE);
        drain();

        load_config('0, '0, '0, '0, '0, '0);
        send_item(CMD_RESTART, 64'd0);
        send_item(CMD_GEN, 64'd0);
        run_random(RANDOM_PER_PHASE);
        drain();

        load_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        send_item(CMD_RESTART, {$urandom, $urandom});
        run_random(RANDOM_PER_PHASE);
        drain();

        // low half close to the top so increments carry across the halves
        load_config($urandom, $urandom, 32'hFFFF_FFFF - $urandom_range(0, 20), '1,
                    $urandom, $urandom);
        send_item(CMD_RESTART, {$urandom, $urandom});
        run_random(RANDOM_PER_PHASE);
        drain();

        load_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        send_item(CMD_RESTART, {$urandom, $urandom});
        run_random(RANDOM_PER_PHASE);
        drain();

        if (mismatches == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
